// ----- hdl/idstk_pkg.sv -----
`default_nettype none

package idstk_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int WORD_WIDTH_DEF  = 32;

  // fixed field widths of the stream words
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // cells read out per first-level OR group
  localparam int GROUP = 8;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_REDUCE
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM
  } cell_op_t;

endpackage

`default_nettype wire

// ----- hdl/idstk_cell.sv -----
`default_nettype none

module idstk_cell #(
  parameter int IDX = 0,
  parameter int AW  = 6,
  parameter int WW  = 32
) (
  input  wire                   clk,
  input  idstk_pkg::cell_op_t   op,
  input  wire  [AW-1:0]         tgt,
  input  wire  [AW-1:0]         rd_idx,
  input  wire  [WW-1:0]         value,
  input  wire  [WW-1:0]         below,
  input  wire  [WW-1:0]         above,
  output logic [WW-1:0]         q,
  output logic [WW-1:0]         rd
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [WW-1:0] data_r;
  logic [WW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      idstk_pkg::OP_INS: begin
        if (MY_IDX == tgt) data_nxt = value;
        else if (MY_IDX > tgt) data_nxt = below;
      end
      idstk_pkg::OP_REM: begin
        // take the word from above at and past the removed slot
        if (MY_IDX >= tgt) data_nxt = above;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q  = data_r;
  assign rd = (MY_IDX == rd_idx) ? data_r : '0;

endmodule

`default_nettype wire

// ----- hdl/indexed_data_stack_core.sv -----
`default_nettype none

// An accepted word is decoded into registers; the gather step updates the cells and
//   registers the first-level readout OR, and the reduce step registers the final OR
//   into the result when the output is free. No new word is taken until then.
// Shifts for insert and remove move the whole row of cells together in the gather step.
// Reset (synchronous, rst_n low) empties the stack and sets error_value to 0;
//   stored words are not cleared.
module indexed_data_stack_core #(
  parameter int STACK_DEPTH = idstk_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = idstk_pkg::WORD_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // command[2:0], value[34:3], position[41:35], zero[47:42]
  input  wire  [idstk_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // result_value[31:0], status[33:32], depth[40:34], zero[47:41]
  output logic [idstk_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [idstk_pkg::VALUE_W-1:0]        cfg_data
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int XW   = (CW > idstk_pkg::POS_W) ? CW : idstk_pkg::POS_W;
  localparam int NGRP = (STACK_DEPTH + idstk_pkg::GROUP - 1) / idstk_pkg::GROUP;
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  // input fields
  logic [idstk_pkg::CMD_W-1:0]   in_cmd;
  logic signed [idstk_pkg::VALUE_W-1:0] in_value;
  logic [idstk_pkg::POS_W-1:0]   in_pos;
  assign in_cmd   = in_tdata[2:0];
  assign in_value = in_tdata[34:3];
  assign in_pos   = in_tdata[41:35];

  idstk_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]  count_r, count_nxt;
  logic [idstk_pkg::VALUE_W-1:0] err_r;

  // latched decode of the current word
  idstk_pkg::cell_op_t op_r, op_nxt;
  logic [AW-1:0]  tgt_r, tgt_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           rd_en_r, rd_en_nxt;
  logic [idstk_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic [CW-1:0]  ncount_r, ncount_nxt;
  logic [WORD_WIDTH-1:0] val_r;

  logic [WORD_WIDTH-1:0] grp_r [NGRP];

  logic                  out_valid_r;
  logic [idstk_pkg::VALUE_W-1:0] out_result_r, out_result_nxt;
  logic [idstk_pkg::STAT_W-1:0]  out_stat_r;
  logic [idstk_pkg::DEPTH_W-1:0] out_depth_r;

  logic in_acc, out_load, grp_load;

  // ---------------- decode ----------------
  logic [XW-1:0] pos_x, cnt_x;
  logic [CW-1:0] cnt_m1;
  logic          is_full, is_empty;

  always_comb begin
    pos_x    = XW'(in_pos);
    cnt_x    = XW'(count_r);
    cnt_m1   = count_r - 1'b1;
    is_full  = (count_r == FULL_CNT);
    is_empty = (count_r == '0);

    op_nxt     = idstk_pkg::OP_HOLD;
    tgt_nxt    = pos_x[AW-1:0];
    rd_idx_nxt = pos_x[AW-1:0];
    rd_en_nxt  = 1'b0;
    stat_nxt   = idstk_pkg::ST_OK;
    ncount_nxt = count_r;
    case (in_cmd)
      idstk_pkg::CMD_PUSH: begin
        if (is_full) stat_nxt = idstk_pkg::ST_FULL;
        else begin
          op_nxt     = idstk_pkg::OP_INS;
          tgt_nxt    = count_r[AW-1:0];
          ncount_nxt = count_r + 1'b1;
        end
      end
      idstk_pkg::CMD_POP: begin
        if (is_empty) stat_nxt = idstk_pkg::ST_EMPTY;
        else begin
          rd_idx_nxt = cnt_m1[AW-1:0];
          rd_en_nxt  = 1'b1;
          ncount_nxt = cnt_m1;
        end
      end
      idstk_pkg::CMD_PEEK: begin
        if (is_empty) stat_nxt = idstk_pkg::ST_EMPTY;
        else begin
          rd_idx_nxt = cnt_m1[AW-1:0];
          rd_en_nxt  = 1'b1;
        end
      end
      idstk_pkg::CMD_INSERT: begin
        if (is_full) stat_nxt = idstk_pkg::ST_FULL;
        else if (pos_x > cnt_x) stat_nxt = idstk_pkg::ST_RANGE;
        else begin
          op_nxt     = idstk_pkg::OP_INS;
          ncount_nxt = count_r + 1'b1;
        end
      end
      idstk_pkg::CMD_REMOVE: begin
        if (is_empty) stat_nxt = idstk_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x) stat_nxt = idstk_pkg::ST_RANGE;
        else begin
          op_nxt     = idstk_pkg::OP_REM;
          rd_en_nxt  = 1'b1;
          ncount_nxt = cnt_m1;
        end
      end
      idstk_pkg::CMD_READ: begin
        if (is_empty) stat_nxt = idstk_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x) stat_nxt = idstk_pkg::ST_RANGE;
        else rd_en_nxt = 1'b1;
      end
      idstk_pkg::CMD_CLEAR: ncount_nxt = '0;
      default: stat_nxt = idstk_pkg::ST_OK;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      idstk_pkg::S_IDLE:   if (in_tvalid) state_nxt = idstk_pkg::S_GATHER;
      idstk_pkg::S_GATHER: state_nxt = idstk_pkg::S_REDUCE;
      idstk_pkg::S_REDUCE: if (!out_valid_r || out_tready) state_nxt = idstk_pkg::S_IDLE;
      default:             state_nxt = idstk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    grp_load  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      idstk_pkg::S_IDLE:   in_tready = 1'b1;
      idstk_pkg::S_GATHER: grp_load  = 1'b1;
      idstk_pkg::S_REDUCE: out_load  = !out_valid_r || out_tready;
      default:             in_tready = 1'b0;
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---------------- row of cells ----------------
  logic [WORD_WIDTH-1:0] cell_q  [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] cell_rd [STACK_DEPTH];
  idstk_pkg::cell_op_t   cell_op;

  assign cell_op = grp_load ? op_r : idstk_pkg::OP_HOLD;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] below_w, above_w;
    if (i == 0) begin : g_bot
      assign below_w = val_r;
    end else begin : g_mid_b
      assign below_w = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_top
      assign above_w = '0;
    end else begin : g_mid_a
      assign above_w = cell_q[i+1];
    end
    idstk_cell #(
      .IDX (i),
      .AW  (AW),
      .WW  (WORD_WIDTH)
    ) u_cell (
      .clk    (clk),
      .op     (cell_op),
      .tgt    (tgt_r),
      .rd_idx (rd_idx_r),
      .value  (val_r),
      .below  (below_w),
      .above  (above_w),
      .q      (cell_q[i]),
      .rd     (cell_rd[i])
    );
  end

  // ---------------- readout tree ----------------
  logic [WORD_WIDTH-1:0] grp_nxt [NGRP];
  logic [WORD_WIDTH-1:0] rd_word;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < idstk_pkg::GROUP; j++) begin
        if (g * idstk_pkg::GROUP + j < STACK_DEPTH)
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * idstk_pkg::GROUP + j];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) rd_word = rd_word | grp_r[g];
    if (rd_en_r) out_result_nxt = idstk_pkg::VALUE_W'($signed(rd_word));
    else         out_result_nxt = err_r;
  end

  // ---------------- registers ----------------
  always_comb begin
    count_nxt = count_r;
    if (grp_load) count_nxt = ncount_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idstk_pkg::S_IDLE;
      count_r     <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) err_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_nxt;
      tgt_r    <= tgt_nxt;
      rd_idx_r <= rd_idx_nxt;
      rd_en_r  <= rd_en_nxt;
      stat_r   <= stat_nxt;
      ncount_r <= ncount_nxt;
      val_r    <= WORD_WIDTH'(in_value);
    end
    if (grp_load) begin
      for (int g = 0; g < NGRP; g++) grp_r[g] <= grp_nxt[g];
    end
    if (out_load) begin
      out_result_r <= out_result_nxt;
      out_stat_r   <= stat_r;
      out_depth_r  <= idstk_pkg::DEPTH_W'(ncount_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_depth_r, out_stat_r, out_result_r};

  // ---------------- checks ----------------
  a_acc_to_gather: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == idstk_pkg::S_GATHER)
    else $error("accepted word did not enter gather step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stack count above depth");

  a_out_from_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == idstk_pkg::S_REDUCE))
    else $error("result raised outside reduce step");

  a_count_only_in_gather: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != idstk_pkg::S_GATHER) |=> $stable(count_r))
    else $error("count changed outside cell update");

endmodule

`default_nettype wire

// ----- tb/sv/tb_indexed_data_stack_core.sv -----
module tb_indexed_data_stack_core;

  localparam int STACK_CELLS = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL = 400;
  localparam logic [idstk_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [idstk_pkg::CMD_W-1:0] cmd;
    logic [31:0] word;
    logic [idstk_pkg::POS_W-1:0] pos;
  } stack_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [idstk_pkg::STAT_W-1:0] status;
    logic [idstk_pkg::DEPTH_W-1:0] depth;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [idstk_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [idstk_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [idstk_pkg::VALUE_W-1:0] cfg_data = '0;

  indexed_data_stack_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // stack shadow used for prediction
  logic [31:0] stack_words [STACK_CELLS];
  int stack_count = 0;
  logic [31:0] err_word = '0;

  stack_cmd_t pending_cmds[$];
  stack_result_t expected_results[$];
  stack_cmd_t cur_cmd;
  int plan_depth = 0;
  int queued_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  // sender pacing
  bit sender_bursty = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  // receiver pacing
  int stall_req = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  stack_result_t want;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL indexed_data_stack_core");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic stack_result_t stack_apply(input stack_cmd_t c);
    stack_result_t r;
    int i;
    r.word = err_word;
    r.status = idstk_pkg::ST_OK;
    case (c.cmd)
      idstk_pkg::CMD_PUSH: begin
        if (stack_count >= STACK_CELLS) r.status = idstk_pkg::ST_FULL;
        else begin
          stack_words[stack_count] = c.word;
          stack_count++;
        end
      end
      idstk_pkg::CMD_POP: begin
        if (stack_count == 0) r.status = idstk_pkg::ST_EMPTY;
        else begin
          stack_count--;
          r.word = stack_words[stack_count];
        end
      end
      idstk_pkg::CMD_PEEK: begin
        if (stack_count == 0) r.status = idstk_pkg::ST_EMPTY;
        else r.word = stack_words[stack_count-1];
      end
      idstk_pkg::CMD_INSERT: begin
        // full wins over a bad position
        if (stack_count >= STACK_CELLS) r.status = idstk_pkg::ST_FULL;
        else if (int'(c.pos) > stack_count) r.status = idstk_pkg::ST_RANGE;
        else begin
          for (i = stack_count; i > int'(c.pos); i--) stack_words[i] = stack_words[i-1];
          stack_words[c.pos] = c.word;
          stack_count++;
        end
      end
      idstk_pkg::CMD_REMOVE: begin
        if (stack_count == 0) r.status = idstk_pkg::ST_EMPTY;
        else if (int'(c.pos) >= stack_count) r.status = idstk_pkg::ST_RANGE;
        else begin
          r.word = stack_words[c.pos];
          for (i = int'(c.pos); i + 1 < stack_count; i++) stack_words[i] = stack_words[i+1];
          stack_count--;
        end
      end
      idstk_pkg::CMD_READ: begin
        if (stack_count == 0) r.status = idstk_pkg::ST_EMPTY;
        else if (int'(c.pos) >= stack_count) r.status = idstk_pkg::ST_RANGE;
        else r.word = stack_words[c.pos];
      end
      idstk_pkg::CMD_CLEAR: stack_count = 0;
      default: ;
    endcase
    r.depth = stack_count[idstk_pkg::DEPTH_W-1:0];
    return r;
  endfunction

  // driver: present queued commands, in bursts with gaps when bursty pacing is on, predict on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(stack_apply(cur_cmd));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'b0, cur_cmd.pos, cur_cmd.word, cur_cmd.cmd};
          if (burst_left > 0) burst_left--;
          else if (sender_bursty) begin
            burst_left = $urandom_range(0, 24);
            gap_left = $urandom_range(1, 9);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = LONG_STALL;
      end
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (rx_cycle % 5 != 0);
          default: out_tready <= (rx_cycle % 8 == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_tdata));
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.word)
          report_mismatch($sformatf("value got %h want %h", out_tdata[31:0], want.word));
        if (out_tdata[33:32] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_tdata[33:32], want.status));
        if (out_tdata[40:34] !== want.depth)
          report_mismatch($sformatf("depth got %0d want %0d", out_tdata[40:34], want.depth));
      end
    end
  end

  // queue a command and track the depth it will leave, for shaping positions
  task automatic add_cmd(input logic [idstk_pkg::CMD_W-1:0] c, input logic [31:0] w,
                         input int p);
    stack_cmd_t it;
    it.cmd = c;
    it.word = w;
    it.pos = p[idstk_pkg::POS_W-1:0];
    pending_cmds.push_back(it);
    queued_count++;
    case (c)
      idstk_pkg::CMD_PUSH: if (plan_depth < STACK_CELLS) plan_depth++;
      idstk_pkg::CMD_POP: if (plan_depth > 0) plan_depth--;
      idstk_pkg::CMD_INSERT:
        if (plan_depth < STACK_CELLS && int'(it.pos) <= plan_depth) plan_depth++;
      idstk_pkg::CMD_REMOVE: if (plan_depth > 0 && int'(it.pos) < plan_depth) plan_depth--;
      idstk_pkg::CMD_CLEAR: plan_depth = 0;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, plan_depth);
    if (r == 7) return plan_depth;
    return $urandom_range(0, 127);
  endfunction

  task automatic seq_fill();
    while (plan_depth < STACK_CELLS) begin
      if ($urandom_range(0, 1)) add_cmd(idstk_pkg::CMD_PUSH, rand_word(), $urandom_range(0, 127));
      else add_cmd(idstk_pkg::CMD_INSERT, rand_word(), $urandom_range(0, plan_depth));
    end
    add_cmd(idstk_pkg::CMD_PUSH, rand_word(), 0);
    add_cmd(idstk_pkg::CMD_INSERT, rand_word(), 127);
    add_cmd(idstk_pkg::CMD_INSERT, rand_word(), 0);
    add_cmd(idstk_pkg::CMD_INSERT, rand_word(), STACK_CELLS);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, STACK_CELLS - 1);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, STACK_CELLS);
    add_cmd(idstk_pkg::CMD_PEEK, 32'h0, 0);
  endtask

  task automatic seq_drain();
    while (plan_depth > 0) begin
      if ($urandom_range(0, 1)) add_cmd(idstk_pkg::CMD_POP, rand_word(), pick_pos());
      else add_cmd(idstk_pkg::CMD_REMOVE, rand_word(), $urandom_range(0, plan_depth - 1));
    end
    add_cmd(idstk_pkg::CMD_POP, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_PEEK, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_REMOVE, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 0);
  endtask

  task automatic seq_mixed(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 18) add_cmd(idstk_pkg::CMD_PUSH, rand_word(), $urandom_range(0, 127));
      else if (r < 36) add_cmd(idstk_pkg::CMD_INSERT, rand_word(), pick_pos());
      else if (r < 52) add_cmd(idstk_pkg::CMD_POP, rand_word(), $urandom_range(0, 127));
      else if (r < 68) add_cmd(idstk_pkg::CMD_REMOVE, rand_word(), pick_pos());
      else if (r < 76) add_cmd(idstk_pkg::CMD_PEEK, rand_word(), $urandom_range(0, 127));
      else if (r < 94) add_cmd(idstk_pkg::CMD_READ, rand_word(), pick_pos());
      else if (r < 96) add_cmd(idstk_pkg::CMD_CLEAR, rand_word(), $urandom_range(0, 127));
      else add_cmd(CMD_UNUSED, rand_word(), $urandom_range(0, 127));
    end
  endtask

  task automatic gen_random(input int n);
    int stop_at;
    int r;
    stop_at = queued_count + n;
    while (queued_count < stop_at) begin
      r = $urandom_range(0, 19);
      if (r < 14) seq_mixed($urandom_range(5, 40));
      else if (r < 17) seq_fill();
      else seq_drain();
    end
  endtask

  // hold until every queued word is accepted and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_error_value(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    err_word = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, error value still at its reset value
    add_cmd(idstk_pkg::CMD_POP, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_PEEK, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_REMOVE, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_INSERT, 32'h1, 1);
    add_cmd(idstk_pkg::CMD_INSERT, WORD_MAX, 0);
    add_cmd(idstk_pkg::CMD_PUSH, WORD_MIN, 0);
    add_cmd(idstk_pkg::CMD_INSERT, 32'hffff_ffff, 0);
    add_cmd(idstk_pkg::CMD_INSERT, 32'h1234_5678, 3);
    add_cmd(idstk_pkg::CMD_INSERT, 32'h5, 127);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 4);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 127);
    add_cmd(idstk_pkg::CMD_REMOVE, 32'h0, 4);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 1);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 2);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 3);
    add_cmd(idstk_pkg::CMD_PEEK, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_REMOVE, 32'h0, 1);
    add_cmd(CMD_UNUSED, 32'hdead_beef, 127);
    add_cmd(idstk_pkg::CMD_REMOVE, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_POP, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_CLEAR, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_POP, 32'h0, 0);
    add_cmd(idstk_pkg::CMD_READ, 32'h0, 0);
    wait_drained();

    write_error_value(WORD_MIN);
    sender_bursty = 1'b1;
    seq_fill();
    gen_random(350);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    write_error_value(WORD_MAX);
    stall_req++;
    gen_random(400);
    wait_drained();

    // sender pauses mid-phase until all results are back
    write_error_value(32'hffff_ffff);
    gen_random(300);
    wait_drained();
    gen_random(300);
    wait_drained();

    write_error_value($urandom);
    sender_bursty = 1'b0;
    gen_random(200);
    wait_drained();
    sender_bursty = 1'b1;
    gen_random(200);
    wait_drained();

    write_error_value(32'h0);
    gen_random(100);
    wait_drained();
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("PASS indexed_data_stack_core");
    end else begin
      $display("FAIL indexed_data_stack_core");
    end
    $finish;
  end

endmodule
